// ===== src/upq_pkg.sv =====
`timescale 1ns / 1ps
// upq_pkg: shared types, codes and the key compare for the urgency/age queue.
// No dependencies; used by every module of the block.
package upq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_W        = 16;
   localparam int URG_W       = 2;
   localparam int TIME_W      = 32;
   localparam int OCC_W       = 5;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   localparam logic [URG_W-1:0] URG_CRITICAL = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [URG_W-1:0]  urg;
      logic [TIME_W-1:0] tim;
   } entry_type;

   // broadcast to every cell for the word in flight
   typedef struct packed {
      logic      ins;
      logic      del_id;
      entry_type key;
   } cmd_type;

   // handed from a cell to its right neighbour
   typedef struct packed {
      logic ins;
      logic hit;
   } link_type;

   // true when key a ranks strictly ahead of key b
   function automatic logic ranks_ahead(entry_type a, entry_type b);
      logic r;
      if (a.urg != b.urg) begin
         r = (a.urg > b.urg);
      end else begin
         r = (a.tim < b.tim);
      end
      return r;
   endfunction

endpackage

// ===== src/urgency_age_priority_queue.sv =====
`timescale 1ns / 1ps
// urgency_age_priority_queue: top level, a row of upq_cell slots plus the
// fill count and the result register. Depends on upq_pkg and upq_cell.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. busy is high only while reset is held, so one word may be
//   issued every cycle.
//   Result channel: one result word per command, on the rsp_ ports for one
//   cycle with rsp_strobe high, in the cycle after the command is taken.
//   Throughput is one command per cycle: every slot compares the new key and
//   the remove id at once, each cell hands its insert flag to its right
//   neighbour, and the first match ripples from cell to cell in the cycle the command is taken.
//   The head is always slot 0; enqueue shifts the tail right, dequeue and
//   remove shift the tail left.
//   Reset empties the queue (the fill count clears; slot contents are left
//   as they are and are never read past the count) and drops any pending
//   result. The receiver cannot stall, so no result is ever held back.
module urgency_age_priority_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [upq_pkg::ID_W-1:0]    req_entry_id,
   input  logic [upq_pkg::URG_W-1:0]   req_urgency,
   input  logic [upq_pkg::TIME_W-1:0]  req_arrival_time,
   output logic                        rsp_strobe,
   output logic [1:0]                  rsp_status,
   output logic [upq_pkg::ID_W-1:0]    rsp_head_id,
   output logic [upq_pkg::URG_W-1:0]   rsp_head_urgency,
   output logic [upq_pkg::TIME_W-1:0]  rsp_head_time,
   output logic [upq_pkg::OCC_W-1:0]   rsp_occupancy
);

   localparam int D = upq_pkg::QUEUE_DEPTH;

   logic [upq_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      strobe_ff, strobe_in;
   upq_pkg::status_type       status_ff, status_in;
   upq_pkg::entry_type        head_ff, head_in;
   logic [upq_pkg::OCC_W-1:0] occ_ff, occ_in;

   upq_pkg::cmd_type   cmd;
   upq_pkg::op_type    op;
   upq_pkg::link_type  link [D+1];
   upq_pkg::entry_type ent  [D];
   logic               take, full, empty, del_head, found;

   assign busy  = reset;
   assign take  = start && !busy;
   assign op    = upq_pkg::op_type'(req_operation);
   assign full  = (count_ff == upq_pkg::CNT_W'(D));
   assign empty = (count_ff == '0);

   assign cmd.ins     = take && (op == upq_pkg::OP_ENQUEUE) && !full;
   assign cmd.del_id  = take && (op == upq_pkg::OP_REMOVE);
   assign cmd.key.id  = req_entry_id;
   assign cmd.key.urg = (req_urgency > upq_pkg::URG_CRITICAL) ? upq_pkg::URG_CRITICAL
                                                              : req_urgency;
   assign cmd.key.tim = req_arrival_time;
   assign del_head    = take && (op == upq_pkg::OP_DEQUEUE) && !empty;

   assign link[0].ins = 1'b0;
   assign link[0].hit = del_head;

   for (genvar i = 0; i < D; i++) begin : g_cell
      upq_pkg::entry_type left_e, right_e;
      if (i == 0) begin : g_first
         assign left_e = ent[0];
      end else begin : g_mid
         assign left_e = ent[i-1];
      end
      if (i == D - 1) begin : g_last
         assign right_e = ent[i];
      end else begin : g_inner
         assign right_e = ent[i+1];
      end
      upq_cell u_cell (
         .clock   (clock),
         .live    (upq_pkg::CNT_W'(i) < count_ff),
         .cmd     (cmd),
         .link_l  (link[i]),
         .entry_l (left_e),
         .entry_r (right_e),
         .link_r  (link[i+1]),
         .entry   (ent[i])
      );
   end

   assign found = cmd.del_id && link[D].hit;

   always_comb begin
      count_in  = count_ff;
      status_in = upq_pkg::ST_OK;
      head_in   = '0;
      case (op)
         upq_pkg::OP_ENQUEUE: begin
            if (full) begin
               status_in = upq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         upq_pkg::OP_DEQUEUE: begin
            if (empty) begin
               status_in = upq_pkg::ST_EMPTY;
            end else begin
               head_in  = ent[0];
               count_in = count_ff - 1'b1;
            end
         end
         upq_pkg::OP_REMOVE: begin
            if (found) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = upq_pkg::ST_NOT_FOUND;
            end
         end
         upq_pkg::OP_NONE: begin
            status_in = upq_pkg::ST_OK;
         end
         default: begin
            status_in = upq_pkg::ST_OK;
         end
      endcase
      if (!take) begin
         count_in = count_ff;
      end
      strobe_in = take;
      occ_in    = upq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      head_ff   <= head_in;
      occ_ff    <= occ_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_head_id      = head_ff.id;
   assign rsp_head_urgency = head_ff.urg;
   assign rsp_head_time    = head_ff.tim;
   assign rsp_occupancy    = occ_ff;

endmodule

// ===== src/upq_cell.sv =====
`timescale 1ns / 1ps
// upq_cell: one slot of the sorted chain; inserts, shifts right on insert,
// shifts left on removal. Depends on upq_pkg.
module upq_cell (
   input  logic                clock,
   input  logic                live,
   input  upq_pkg::cmd_type    cmd,
   input  upq_pkg::link_type   link_l,
   input  upq_pkg::entry_type  entry_l,
   input  upq_pkg::entry_type  entry_r,
   output upq_pkg::link_type   link_r,
   output upq_pkg::entry_type  entry
);

   upq_pkg::entry_type entry_ff, entry_in;
   logic               match;

   assign match      = live && cmd.del_id && (entry_ff.id == cmd.key.id);
   assign link_r.hit = link_l.hit || match;
   assign link_r.ins = cmd.ins && (!live || upq_pkg::ranks_ahead(cmd.key, entry_ff));
   assign entry      = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (link_r.ins) begin
         entry_in = link_l.ins ? entry_l : cmd.key;
      end else if (link_r.hit) begin
         entry_in = entry_r;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== src/upq_checker.sv =====
`timescale 1ns / 1ps
// upq_checker: port-level checks on the queue's command and result words,
// bound to the top level. Depends on upq_pkg.
module upq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [1:0]                  rsp_status,
   input logic [upq_pkg::ID_W-1:0]    rsp_head_id,
   input logic [upq_pkg::URG_W-1:0]   rsp_head_urgency,
   input logic [upq_pkg::TIME_W-1:0]  rsp_head_time,
   input logic [upq_pkg::OCC_W-1:0]   rsp_occupancy
);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("command without result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without command");

   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != upq_pkg::ST_OK) |->
         (rsp_head_id == '0 && rsp_head_urgency == '0 && rsp_head_time == '0))
      else $error("head fields set on failure");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == upq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with entries held");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == upq_pkg::ST_FULL) |->
         (rsp_occupancy == upq_pkg::OCC_W'(upq_pkg::QUEUE_DEPTH)))
      else $error("full status below depth");

endmodule

bind urgency_age_priority_queue upq_checker u_upq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_head_id      (rsp_head_id),
   .rsp_head_urgency (rsp_head_urgency),
   .rsp_head_time    (rsp_head_time),
   .rsp_occupancy    (rsp_occupancy)
);
